// ===== rtl/core/fat12cw_pkg.sv =====
// ----------------------------------------------------------------------------
// fat12cw_pkg
// Shared types and constants of the FAT12 cluster chain walker.
// ----------------------------------------------------------------------------
package fat12cw_pkg;

  localparam int FAT_BYTES_DEFAULT = 8192;
  localparam int MAX_SPC_DEFAULT   = 64;

  localparam int ADDR_W    = 13;   // table_address
  localparam int CLUSTER_W = 12;   // cluster_number, next_cluster
  localparam int SECTOR_W  = 32;
  localparam int SPC_W     = 7;
  localparam int DATA_W    = 16;   // widest config register
  localparam int CFG_IDX_W = 3;
  localparam int DS_W      = 20;   // reserved + copies*spf + root

  localparam int QUEUE_DEPTH = 4;

  localparam logic [CLUSTER_W-1:0] CHAIN_END_LOW = 12'hFF8;

  localparam logic KIND_LOAD   = 1'b0;
  localparam logic KIND_FOLLOW = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_RESERVED = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COPIES   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPF      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ROOT     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPC      = 3'd4;

  typedef struct packed {
    logic [15:0]      reserved_sectors;
    logic [2:0]       fat_copies;
    logic [15:0]      sectors_per_fat;
    logic [15:0]      root_dir_sectors;
    logic [SPC_W-1:0] sectors_per_cluster;
  } cfg_t;

  // One classified follow request, handed from front to back.
  typedef struct packed {
    logic [SECTOR_W-1:0]  base;
    logic [CLUSTER_W-1:0] next_cluster;
    logic                 chain_end;
    logic [SPC_W-1:0]     spc;
  } job_t;

endpackage

// ===== rtl/core/fat12cw_ifs.sv =====
// ----------------------------------------------------------------------------
// fat12cw_ifs
// Valid/ready channels of the walker: request in, sector results out.
// ----------------------------------------------------------------------------
interface fat12cw_in_if;
  logic                             valid;
  logic                             ready;
  logic                             kind;
  logic [fat12cw_pkg::ADDR_W-1:0]    table_address;
  logic [7:0]                       table_byte;
  logic [fat12cw_pkg::CLUSTER_W-1:0] cluster_number;

  modport source (output valid, kind, table_address, table_byte, cluster_number,
                  input ready);
  modport sink   (input valid, kind, table_address, table_byte, cluster_number,
                  output ready);
endinterface

interface fat12cw_out_if;
  logic                             valid;
  logic                             ready;
  logic [fat12cw_pkg::SECTOR_W-1:0]  sector_number;
  logic [fat12cw_pkg::CLUSTER_W-1:0] next_cluster;
  logic                             chain_end;
  logic                             last;

  modport source (output valid, sector_number, next_cluster, chain_end, last,
                  input ready);
  modport sink   (input valid, sector_number, next_cluster, chain_end, last,
                  output ready);
endinterface

// ===== rtl/core/fat12_cluster_chain_walker.sv =====
// ----------------------------------------------------------------------------
// fat12_cluster_chain_walker
// FAT12 table store with cluster follow: next cluster, chain end, sectors.
// ----------------------------------------------------------------------------
//  channel  dir  handshake     payload
//  in_ch    in   valid/ready   kind, table_address, table_byte, cluster_number
//  out_ch   out  valid/ready   sector_number, next_cluster, chain_end, last
//  cfg      in   cfg_we only   cfg_index, cfg_data (no read-back)
//
//  A load request writes its table byte when accepted. A follow request reads
//  the table when accepted, is decoded into the queue from the front's stage 1
//  registers, and its sector results then enter the output register from the
//  queue head, one sector result per cycle while out_ch does not stall, up to
//  sectors_per_cluster results: the back's counter sets the rate.
//  rst is synchronous: config returns to 1/2/9/14/1, queue and output empty.
//  The table store is not cleared; entries read before written are undefined.
//  in_ch stalls (loads too) while queued jobs plus the one in decode fill the
//  four queue slots; out_ch stalls hold the output register.
// ----------------------------------------------------------------------------
module fat12_cluster_chain_walker #(
  parameter int FAT_BYTES               = fat12cw_pkg::FAT_BYTES_DEFAULT,
  parameter int MAX_SECTORS_PER_CLUSTER = fat12cw_pkg::MAX_SPC_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  fat12cw_in_if.sink                        in_ch,
  fat12cw_out_if.source                     out_ch,
  input  logic                              cfg_we,
  input  logic [fat12cw_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [fat12cw_pkg::DATA_W-1:0]    cfg_data
);

  fat12cw_pkg::cfg_t cfg;
  fat12cw_pkg::job_t push_job;
  fat12cw_pkg::job_t head_job;
  logic              push;
  logic              pop;
  logic              head_valid;
  logic [$clog2(fat12cw_pkg::QUEUE_DEPTH+1)-1:0] queue_count;

  // configuration registers; writes must only arrive while idle, which the block does not enforce
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.reserved_sectors    <= 16'd1;
      cfg.fat_copies          <= 3'd2;
      cfg.sectors_per_fat     <= 16'd9;
      cfg.root_dir_sectors    <= 16'd14;
      cfg.sectors_per_cluster <= 7'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        fat12cw_pkg::CFG_RESERVED: cfg.reserved_sectors    <= cfg_data;
        fat12cw_pkg::CFG_COPIES:   cfg.fat_copies          <= cfg_data[2:0];
        fat12cw_pkg::CFG_SPF:      cfg.sectors_per_fat     <= cfg_data;
        fat12cw_pkg::CFG_ROOT:     cfg.root_dir_sectors    <= cfg_data;
        fat12cw_pkg::CFG_SPC:      cfg.sectors_per_cluster <= cfg_data[6:0];
        default: begin
          // unused index: ignored
        end
      endcase
    end
  end

  // front: table writes, entry fetch/decode, sector base
  fat12cw_front #(
    .FAT_BYTES               (FAT_BYTES),
    .MAX_SECTORS_PER_CLUSTER (MAX_SECTORS_PER_CLUSTER)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_ch       (in_ch),
    .cfg         (cfg),
    .queue_count (queue_count),
    .push        (push),
    .push_job    (push_job)
  );

  fat12cw_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (push_job),
    .pop        (pop),
    .head_valid (head_valid),
    .head_job   (head_job),
    .count      (queue_count)
  );

  // back: one sector result per cycle while a job is queued and out_ch does not stall
  fat12cw_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (pop),
    .out_ch     (out_ch)
  );

endmodule

// ===== rtl/core/fat12cw_ram.sv =====
// ----------------------------------------------------------------------------
// fat12cw_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fat12cw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/fat12cw_front.sv =====
// ----------------------------------------------------------------------------
// fat12cw_front
// Accepts requests, writes table bytes, fetches and decodes FAT entries.
// ----------------------------------------------------------------------------
module fat12cw_front #(
  parameter int FAT_BYTES               = fat12cw_pkg::FAT_BYTES_DEFAULT,
  parameter int MAX_SECTORS_PER_CLUSTER = fat12cw_pkg::MAX_SPC_DEFAULT
) (
  input  logic                                     clk,
  input  logic                                     rst,
  fat12cw_in_if.sink                               in_ch,
  input  fat12cw_pkg::cfg_t                        cfg,
  input  logic [$clog2(fat12cw_pkg::QUEUE_DEPTH+1)-1:0] queue_count,
  output logic                                     push,
  output fat12cw_pkg::job_t                        push_job
);

  localparam int BANK_DEPTH = (FAT_BYTES + 1) / 2;
  localparam int BANK_AW    = $clog2(BANK_DEPTH);
  localparam int CNT_W      = $clog2(fat12cw_pkg::QUEUE_DEPTH + 1);

  // Byte store is split into even and odd banks so both entry bytes
  // come out in one read.
  logic               accept;
  logic               wr_ok;
  logic [31:0]        waddr_full;
  logic [BANK_AW-1:0] waddr;
  logic [12:0]        offset;
  logic [11:0]        half;
  logic [31:0]        even_full;
  logic [31:0]        odd_full;
  logic [BANK_AW-1:0] even_raddr;
  logic [BANK_AW-1:0] odd_raddr;
  logic [7:0]         even_q;
  logic [7:0]         odd_q;
  logic [fat12cw_pkg::SPC_W-1:0] spc_clamped;
  logic [31:0]        prod;
  logic [fat12cw_pkg::DS_W-1:0] ds;
  logic [15:0]        word;
  logic [fat12cw_pkg::CLUSTER_W-1:0] entry;

  // stage 1 registers
  logic               f1_valid;
  logic               f1_swap;
  logic               f1_odd;
  logic [31:0]        f1_prod;
  logic [fat12cw_pkg::DS_W-1:0] f1_ds;
  logic [fat12cw_pkg::SPC_W-1:0] f1_spc;

  // credit: queue slots plus the one in flight
  assign in_ch.ready = ({1'b0, queue_count} + (CNT_W+1)'(f1_valid))
                       < (CNT_W+1)'(fat12cw_pkg::QUEUE_DEPTH);
  assign accept = in_ch.valid && in_ch.ready;

  assign waddr_full = 32'(in_ch.table_address) >> 1;
  assign waddr      = waddr_full[BANK_AW-1:0];
  assign wr_ok      = accept && (in_ch.kind == fat12cw_pkg::KIND_LOAD) &&
                      (32'(in_ch.table_address) < 32'(FAT_BYTES));

  assign offset     = 13'(in_ch.cluster_number) + 13'(in_ch.cluster_number >> 1);
  assign half       = offset[12:1];
  assign even_full  = offset[0] ? 32'(half) + 32'd1 : 32'(half);
  assign odd_full   = 32'(half);
  assign even_raddr = even_full[BANK_AW-1:0];
  assign odd_raddr  = odd_full[BANK_AW-1:0];

  fat12cw_ram #(.WIDTH(8), .DEPTH(BANK_DEPTH)) u_even (
    .clk   (clk),
    .we    (wr_ok && !in_ch.table_address[0]),
    .waddr (waddr),
    .wdata (in_ch.table_byte),
    .raddr (even_raddr),
    .rdata (even_q)
  );

  fat12cw_ram #(.WIDTH(8), .DEPTH(BANK_DEPTH)) u_odd (
    .clk   (clk),
    .we    (wr_ok && in_ch.table_address[0]),
    .waddr (waddr),
    .wdata (in_ch.table_byte),
    .raddr (odd_raddr),
    .rdata (odd_q)
  );

  always_comb begin
    if (cfg.sectors_per_cluster == '0) begin
      spc_clamped = fat12cw_pkg::SPC_W'(1);
    end else if (32'(cfg.sectors_per_cluster) > 32'(MAX_SECTORS_PER_CLUSTER)) begin
      spc_clamped = fat12cw_pkg::SPC_W'(MAX_SECTORS_PER_CLUSTER);
    end else begin
      spc_clamped = cfg.sectors_per_cluster;
    end
  end

  assign prod = (32'(in_ch.cluster_number) - 32'd2) * 32'(spc_clamped);
  assign ds   = fat12cw_pkg::DS_W'(cfg.reserved_sectors)
              + fat12cw_pkg::DS_W'(cfg.fat_copies) * fat12cw_pkg::DS_W'(cfg.sectors_per_fat)
              + fat12cw_pkg::DS_W'(cfg.root_dir_sectors);

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid <= 1'b0;
    end else begin
      f1_valid <= accept && (in_ch.kind == fat12cw_pkg::KIND_FOLLOW);
    end
    f1_swap <= offset[0];
    f1_odd  <= in_ch.cluster_number[0];
    f1_prod <= prod;
    f1_ds   <= ds;
    f1_spc  <= spc_clamped;
  end

  // little-endian word at the entry offset
  assign word  = f1_swap ? {even_q, odd_q} : {odd_q, even_q};
  assign entry = f1_odd ? word[15:4] : word[11:0];

  assign push                  = f1_valid;
  assign push_job.base         = 32'(f1_ds) + f1_prod;
  assign push_job.next_cluster = entry;
  assign push_job.chain_end    = entry >= fat12cw_pkg::CHAIN_END_LOW;
  assign push_job.spc          = f1_spc;

endmodule

// ===== rtl/core/fat12cw_queue.sv =====
// ----------------------------------------------------------------------------
// fat12cw_queue
// Small register FIFO of decoded follow jobs between front and back.
// ----------------------------------------------------------------------------
module fat12cw_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  fat12cw_pkg::job_t push_job,
  input  logic              pop,
  output logic              head_valid,
  output fat12cw_pkg::job_t head_job,
  output logic [$clog2(fat12cw_pkg::QUEUE_DEPTH+1)-1:0] count
);

  localparam int PTR_W = $clog2(fat12cw_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(fat12cw_pkg::QUEUE_DEPTH + 1);

  fat12cw_pkg::job_t slots [fat12cw_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic             do_pop;

  assign head_valid = count != '0;
  assign head_job   = slots[rd_ptr];
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      count <= count + CNT_W'(push) - CNT_W'(do_pop);
    end
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

endmodule

// ===== rtl/core/fat12cw_back.sv =====
// ----------------------------------------------------------------------------
// fat12cw_back
// Expands one job into its sector results, one per cycle unless out_ch stalls, into an output reg.
// ----------------------------------------------------------------------------
module fat12cw_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              head_valid,
  input  fat12cw_pkg::job_t head_job,
  output logic              pop,
  fat12cw_out_if.source     out_ch
);

  logic [fat12cw_pkg::SPC_W-1:0] idx;
  logic                          out_valid;
  logic                          advance;
  logic                          is_last;

  assign advance = head_valid && (!out_valid || out_ch.ready);
  assign is_last = idx == (head_job.spc - fat12cw_pkg::SPC_W'(1));
  assign pop     = advance && is_last;

  assign out_ch.valid = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      out_valid <= advance || (out_valid && !out_ch.ready);
      if (advance) begin
        idx <= is_last ? '0 : idx + fat12cw_pkg::SPC_W'(1);
      end
    end
    if (advance) begin
      out_ch.sector_number <= head_job.base + 32'(idx);
      out_ch.next_cluster  <= head_job.next_cluster;
      out_ch.chain_end     <= head_job.chain_end;
      out_ch.last          <= is_last;
    end
  end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for fat12_cluster_chain_walker. Table bytes are loaded
// through the request channel and clusters are then followed, alone or as
// chains. Every accepted follow request is predicted into a queue of sector
// results that the output side checks field by field. Both sides idle and
// stall at random, and the volume geometry is changed between phases while
// the block is idle.
// ----------------------------------------------------------------------------
module tb;
  import fat12cw_pkg::*;

  localparam int FAT_BYTES = FAT_BYTES_DEFAULT;
  localparam int MAX_SPC   = MAX_SPC_DEFAULT;
  localparam logic [CLUSTER_W-1:0] CHAIN_END_HIGH = 12'hFFF;

  localparam int SETTLE_CYCLES = 16;    // front pipe plus load, with margin
  localparam int TAIL_CYCLES   = 32;
  localparam int QUIET_LIMIT   = 2000;  // cycles without any handshake

  typedef struct {
    logic                 kind;
    logic [ADDR_W-1:0]    table_address;
    logic [7:0]           table_byte;
    logic [CLUSTER_W-1:0] cluster_number;
  } req_t;

  typedef struct {
    logic [SECTOR_W-1:0]  sector_number;
    logic [CLUSTER_W-1:0] next_cluster;
    logic                 chain_end;
    logic                 last;
  } sector_t;

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DATA_W-1:0]    cfg_data;

  fat12cw_in_if  req_if ();
  fat12cw_out_if sec_if ();

  fat12_cluster_chain_walker i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (req_if),
    .out_ch    (sec_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // --- predictor state: table image and volume geometry as the block sees them
  logic [7:0] fat_image [FAT_BYTES];
  cfg_t       volume;
  sector_t    pending_sectors [$];

  // --- stimulus planning: what the table will hold once the queued loads land
  req_t       req_q [$];
  logic [7:0] plan_bytes [FAT_BYTES];
  bit         plan_written [FAT_BYTES];
  int         mapped_clusters [$];
  int         planned;

  int fault_count;
  int quiet_cycles;
  bit req_taken;
  bit req_calm;
  bit sec_calm;
  int req_gap;
  int sec_stall;

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // ---------------------------------------------------------------------------
  // FAT12 entry decode: little-endian word at cluster*3/2, odd clusters take
  // the upper 12 bits.
  // ---------------------------------------------------------------------------
  function automatic int entry_offset(input logic [CLUSTER_W-1:0] c);
    return (int'(c) * 3) / 2;
  endfunction

  function automatic logic [CLUSTER_W-1:0] decode_entry(input logic [7:0] lo,
                                                        input logic [7:0] hi,
                                                        input logic odd);
    logic [15:0] word;
    word = {hi, lo};
    return odd ? word[15:4] : word[11:0];
  endfunction

  // One follow request -> one result per sector of the cluster.
  task automatic predict_follow(input logic [CLUSTER_W-1:0] c);
    int                   off;
    int                   spc;
    logic [CLUSTER_W-1:0] nxt;
    logic                 end_flag;
    logic [31:0]          cl;
    logic [31:0]          first_data_sector;
    logic [31:0]          base;
    sector_t              s;
    off      = entry_offset(c);
    nxt      = decode_entry(fat_image[off], fat_image[off+1], c[0]);
    end_flag = (nxt >= CHAIN_END_LOW) && (nxt <= CHAIN_END_HIGH);
    // count is clamped to 1..MAX_SPC and used as the multiplier too
    spc = int'(volume.sectors_per_cluster);
    if (spc < 1) spc = 1;
    if (spc > MAX_SPC) spc = MAX_SPC;
    cl                = 32'(c);
    first_data_sector = 32'(volume.reserved_sectors)
                      + 32'(volume.fat_copies) * 32'(volume.sectors_per_fat)
                      + 32'(volume.root_dir_sectors);
    // clusters 0 and 1 wrap through (cl - 2), all mod 2^32
    base = first_data_sector + (cl - 32'd2) * 32'(spc);
    for (int i = 0; i < spc; i++) begin
      s.sector_number = base + 32'(i);
      s.next_cluster  = nxt;
      s.chain_end     = end_flag;
      s.last          = (i == spc - 1);
      pending_sectors.push_back(s);
    end
  endtask

  task automatic check_sector();
    sector_t want;
    if (pending_sectors.size() == 0) begin
      $error("unexpected sector result: sector_number %0h", sec_if.sector_number);
      fault_count++;
      return;
    end
    want = pending_sectors.pop_front();
    if (sec_if.sector_number !== want.sector_number) begin
      $error("sector_number: expected %0h, got %0h", want.sector_number,
             sec_if.sector_number);
      fault_count++;
    end
    if (sec_if.next_cluster !== want.next_cluster) begin
      $error("next_cluster: expected %0h, got %0h", want.next_cluster,
             sec_if.next_cluster);
      fault_count++;
    end
    if (sec_if.chain_end !== want.chain_end) begin
      $error("chain_end: expected %0b, got %0b", want.chain_end, sec_if.chain_end);
      fault_count++;
    end
    if (sec_if.last !== want.last) begin
      $error("last: expected %0b, got %0b", want.last, sec_if.last);
      fault_count++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Request planning. Follows only ever name clusters whose two entry bytes
  // have been loaded; the store is undefined until written.
  // ---------------------------------------------------------------------------
  function automatic void push_req(input req_t r);
    req_q.push_back(r);
    planned++;
  endfunction

  function automatic void plan_load(input int addr, input logic [7:0] value);
    req_t r;
    r.kind           = KIND_LOAD;
    r.table_address  = ADDR_W'(addr);
    r.table_byte     = value;
    r.cluster_number = CLUSTER_W'($urandom);   // don't care on a load
    plan_bytes[addr]   = value;
    plan_written[addr] = 1'b1;
    push_req(r);
  endfunction

  function automatic void plan_follow(input logic [CLUSTER_W-1:0] c);
    req_t r;
    r.kind           = KIND_FOLLOW;
    r.table_address  = ADDR_W'($urandom);   // don't care on a follow
    r.table_byte     = 8'($urandom);
    r.cluster_number = c;
    push_req(r);
  endfunction

  // Write a 12-bit entry as two byte loads, keeping the neighbor's nibble.
  function automatic void plan_entry(input logic [CLUSTER_W-1:0] c,
                                     input logic [CLUSTER_W-1:0] v);
    int         off;
    logic [7:0] lo;
    logic [7:0] hi;
    off = entry_offset(c);
    if (c[0]) begin
      lo = {v[3:0], plan_bytes[off][3:0]};
      hi = v[11:4];
    end else begin
      lo = v[7:0];
      hi = {plan_bytes[off+1][7:4], v[11:8]};
    end
    plan_load(off, lo);
    plan_load(off + 1, hi);
    mapped_clusters.push_back(c);
  endfunction

  function automatic bit entry_ready(input logic [CLUSTER_W-1:0] c);
    int off;
    off = entry_offset(c);
    return plan_written[off] && plan_written[off+1];
  endfunction

  function automatic logic [CLUSTER_W-1:0] planned_entry(input logic [CLUSTER_W-1:0] c);
    int off;
    off = entry_offset(c);
    return decode_entry(plan_bytes[off], plan_bytes[off+1], c[0]);
  endfunction

  // A quarter of the entries end the chain.
  function automatic logic [CLUSTER_W-1:0] random_entry();
    if ($urandom_range(0, 3) == 0) return CHAIN_END_LOW + 12'($urandom_range(0, 7));
    return 12'($urandom);
  endfunction

  // Mostly well-formed work (write entry then follow, chain walks), the rest
  // stray byte loads and repeat follows.
  task automatic plan_random(input int n);
    int                   target;
    int                   pick;
    int                   steps;
    bit                   walking;
    logic [CLUSTER_W-1:0] c;
    target = planned + n;
    while (planned < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
        plan_load($urandom_range(0, FAT_BYTES - 1), 8'($urandom));
      end else if (pick < 55) begin
        c = 12'($urandom);
        plan_entry(c, random_entry());
        plan_follow(c);
      end else if (pick < 75) begin
        c = 12'(mapped_clusters[$urandom_range(0, mapped_clusters.size() - 1)]);
        plan_follow(c);
      end else begin
        // walk a chain: fill in missing links, stop at a chain end
        c       = 12'(mapped_clusters[$urandom_range(0, mapped_clusters.size() - 1)]);
        steps   = $urandom_range(2, 5);
        walking = 1'b1;
        for (int k = 0; k < steps && walking; k++) begin
          if (!entry_ready(c)) plan_entry(c, random_entry());
          plan_follow(c);
          c       = planned_entry(c);
          walking = (c < CHAIN_END_LOW);
        end
      end
    end
  endtask

  // Geometry writes only while idle; shadow is updated with the masked value.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      CFG_RESERVED: volume.reserved_sectors    = data;
      CFG_COPIES:   volume.fat_copies          = data[2:0];
      CFG_SPF:      volume.sectors_per_fat     = data;
      CFG_ROOT:     volume.root_dir_sectors    = data;
      CFG_SPC:      volume.sectors_per_cluster = data[SPC_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Wait out queued requests and results, then let trailing loads finish.
  task automatic settle(input int cycles);
    while (req_q.size() != 0 || req_if.valid || pending_sectors.size() != 0)
      @(posedge clk);
    repeat (cycles) @(posedge clk);
  endtask

  // Mostly short gaps, now and then a long one.
  function automatic int idle_span();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 8);
    return $urandom_range(12, 40);
  endfunction

  // ---------------------------------------------------------------------------
  // Request driver: falling edge, one request at a time from req_q, with a
  // random gap after each. Calm stretches drive back to back.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin : drive_req
    req_t r;
    if (rst) begin
      req_if.valid <= 1'b0;
    end else if (req_taken || !req_if.valid) begin
      req_taken = 1'b0;
      if (req_gap > 0) begin
        req_gap--;
        req_if.valid <= 1'b0;
      end else if (req_q.size() != 0) begin
        r = req_q.pop_front();
        req_if.valid          <= 1'b1;
        req_if.kind           <= r.kind;
        req_if.table_address  <= r.table_address;
        req_if.table_byte     <= r.table_byte;
        req_if.cluster_number <= r.cluster_number;
        if ($urandom_range(0, 49) == 0) req_calm = !req_calm;
        req_gap = req_calm ? 0 : idle_span();
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  // Result side back-pressure: random stalls, with calm stretches.
  always @(negedge clk) begin
    if (rst) begin
      sec_if.ready <= 1'b0;
    end else begin
      if ($urandom_range(0, 199) == 0) sec_calm = !sec_calm;
      if (sec_stall > 0) begin
        sec_stall--;
        sec_if.ready <= 1'b0;
      end else begin
        sec_if.ready <= 1'b1;
        if (!sec_calm && $urandom_range(0, 3) == 0) sec_stall = idle_span();
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: rising edge. Accepted requests update the predictor, accepted
  // results are checked. The watchdog ends a run that stops moving.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst) begin
      if (req_if.valid && req_if.ready) begin
        req_taken = 1'b1;
        if (req_if.kind == KIND_FOLLOW) predict_follow(req_if.cluster_number);
        else if (req_if.table_address < FAT_BYTES)
          fat_image[req_if.table_address] = req_if.table_byte;
      end
      if (sec_if.valid && sec_if.ready) check_sector();
      if ((req_if.valid && req_if.ready) || (sec_if.valid && sec_if.ready) || cfg_we)
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence of phases
  // ---------------------------------------------------------------------------
  initial begin
    rst                   = 1'b1;
    cfg_we                = 1'b0;
    cfg_index             = CFG_RESERVED;
    cfg_data              = '0;
    req_if.valid          = 1'b0;
    req_if.kind           = KIND_LOAD;
    req_if.table_address  = '0;
    req_if.table_byte     = '0;
    req_if.cluster_number = '0;
    sec_if.ready          = 1'b0;
    fault_count  = 0;
    quiet_cycles = 0;
    planned      = 0;
    req_taken    = 1'b0;
    req_calm     = 1'b0;
    sec_calm     = 1'b0;
    req_gap      = 0;
    sec_stall    = 0;
    for (int a = 0; a < FAT_BYTES; a++) begin
      plan_bytes[a]   = 8'h00;
      plan_written[a] = 1'b0;
    end
    // geometry after reset: 1 / 2 / 9 / 14 / 1
    volume.reserved_sectors    = 16'd1;
    volume.fat_copies          = 3'd2;
    volume.sectors_per_fat     = 16'd9;
    volume.root_dir_sectors    = 16'd14;
    volume.sectors_per_cluster = 7'd1;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: top address with both byte extremes, chain-end bounds,
    // entry just below chain end, zero entry, first and last clusters
    plan_load(FAT_BYTES - 1, 8'hFF);
    plan_load(FAT_BYTES - 1, 8'h00);
    plan_entry(12'd0, CHAIN_END_LOW);
    plan_entry(12'd1, CHAIN_END_HIGH);
    plan_entry(12'd2, 12'hFF7);
    plan_entry(12'd3, 12'h000);
    plan_entry(12'd4094, 12'h543);
    plan_entry(12'd4095, 12'hABC);
    plan_follow(12'd0);
    plan_follow(12'd1);
    plan_follow(12'd2);
    plan_follow(12'd3);
    plan_follow(12'd4094);
    plan_follow(12'd4095);
    settle(SETTLE_CYCLES);

    // tiny volume, spc 0 clamps to 1; clusters 0/1 wrap near 2^32
    write_reg(CFG_RESERVED, 16'h0000);
    write_reg(CFG_COPIES,   16'h0001);
    write_reg(CFG_SPF,      16'h0001);
    write_reg(CFG_ROOT,     16'h0000);
    write_reg(CFG_SPC,      16'h0000);
    plan_follow(12'd0);
    plan_follow(12'd1);
    plan_random(60);
    settle(SETTLE_CYCLES);

    // everything at its top: copies 7 (upper bits junk), spc 127 clamps to 64
    write_reg(CFG_RESERVED, 16'hFFFF);
    write_reg(CFG_COPIES,   16'hFFFF);
    write_reg(CFG_SPF,      16'hFFFF);
    write_reg(CFG_ROOT,     16'hFFFF);
    write_reg(CFG_SPC,      16'h007F);
    plan_random(12);
    settle(SETTLE_CYCLES);

    // largest legal cluster
    write_reg(CFG_RESERVED, 16'($urandom));
    write_reg(CFG_COPIES,   16'h0004);
    write_reg(CFG_SPF,      16'($urandom_range(1, 65535)));
    write_reg(CFG_ROOT,     16'($urandom));
    write_reg(CFG_SPC,      16'h0040);
    plan_random(12);
    settle(SETTLE_CYCLES);

    // zero copies, small clusters, junk above the register widths
    write_reg(CFG_RESERVED, 16'($urandom));
    write_reg(CFG_COPIES,   16'hFFF8);
    write_reg(CFG_SPF,      16'($urandom_range(1, 65535)));
    write_reg(CFG_ROOT,     16'($urandom));
    write_reg(CFG_SPC,      {9'h1FF, 7'($urandom_range(2, 8))});
    plan_random(110);
    settle(SETTLE_CYCLES);

    // typical volumes
    write_reg(CFG_RESERVED, 16'($urandom));
    write_reg(CFG_COPIES,   16'($urandom_range(1, 4)));
    write_reg(CFG_SPF,      16'($urandom_range(1, 65535)));
    write_reg(CFG_ROOT,     16'($urandom));
    write_reg(CFG_SPC,      16'($urandom_range(1, 16)));
    plan_random(110);
    settle(TAIL_CYCLES);

    if (pending_sectors.size() != 0) begin
      $error("%0d sector results never arrived", pending_sectors.size());
      fault_count++;
    end
    if (fault_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/fat12cw_pkg.sv
rtl/core/fat12cw_ifs.sv
rtl/core/fat12cw_ram.sv
rtl/core/fat12cw_front.sv
rtl/core/fat12cw_queue.sv
rtl/core/fat12cw_back.sv
rtl/core/fat12_cluster_chain_walker.sv
test/tb.sv
